>>> rtl/tgr_pkg.sv
// Shared types, constants and the 5x7 font table of the text glyph
// rectangle generator. No dependencies; every other file imports it.
`default_nettype none

package tgr_pkg;

   // Field widths
   localparam int CODE_W          = 8;
   localparam int SCALE_W         = 4;
   localparam int COLOUR_W        = 32;
   localparam int START_W         = 16;
   localparam int COORD_WIDTH_DEF = 16;

   // Offsets added to a coordinate never exceed 9 * 15 = 135
   localparam int OFFSET_W = 8;

   // Glyph geometry and cursor moves
   localparam int GLYPH_ROWS   = 7;
   localparam int GLYPH_COLS   = 5;
   localparam int GLYPH_BITS   = GLYPH_ROWS * GLYPH_COLS;
   localparam int COL_W        = 3;
   localparam int CHAR_ADVANCE = 6;
   localparam int LINE_ADVANCE = 9;

   // Character codes with a meaning of their own
   localparam logic [CODE_W-1:0] NUL_CODE     = 8'h00;
   localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CODE_W-1:0] LOWER_A      = 8'h61;
   localparam logic [CODE_W-1:0] LOWER_Z      = 8'h7A;
   localparam logic [CODE_W-1:0] CASE_SHIFT   = 8'h20;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_SCALE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FILL_COLOUR = 1'd1;

   localparam logic [SCALE_W-1:0]  PIXEL_SCALE_RESET = 4'd1;
   localparam logic [COLOUR_W-1:0] FILL_COLOUR_RESET = 32'd0;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_SCAN,
      ST_ADVANCE,
      ST_NEWLINE
   } tgr_state_type;

   // Control from the sequencer to the datapath
   typedef struct packed {
      logic                emit;
      logic                last;
      logic                row_wr;
      logic                adv_wr;
      logic                line_wr;
      logic                base_y;
      logic [OFFSET_W-1:0] offset;
   } tgr_ctrl_type;

   // Glyph bitmap, row 0 column 0 at the top bit, row-major
   function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0]     key;
      logic [GLYPH_BITS-1:0] rows;
      key = code;
      if (code inside {[LOWER_A:LOWER_Z]}) begin
         key = code - CASE_SHIFT;
      end
      case (key)
         8'h41: rows = {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17}; // A
         8'h42: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30}; // B
         8'h43: rows = {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14}; // C
         8'h44: rows = {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30}; // D
         8'h45: rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31}; // E
         8'h46: rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16}; // F
         8'h47: rows = {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15}; // G
         8'h48: rows = {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17}; // H
         8'h49: rows = {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14}; // I
         8'h4A: rows = {5'd7,  5'd2,  5'd2,  5'd2,  5'd2,  5'd18, 5'd12}; // J
         8'h4B: rows = {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17}; // K
         8'h4C: rows = {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31}; // L
         8'h4D: rows = {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17}; // M
         8'h4E: rows = {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17}; // N
         8'h4F: rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14}; // O
         8'h50: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16}; // P
         8'h51: rows = {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13}; // Q
         8'h52: rows = {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17}; // R
         8'h53: rows = {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30}; // S
         8'h54: rows = {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4};  // T
         8'h55: rows = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14}; // U
         8'h56: rows = {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};  // V
         8'h57: rows = {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10}; // W
         8'h58: rows = {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17}; // X
         8'h59: rows = {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4};  // Y
         8'h5A: rows = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}; // Z
         8'h30: rows = {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14}; // 0
         8'h31: rows = {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14}; // 1
         8'h32: rows = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31}; // 2
         8'h33: rows = {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30}; // 3
         8'h34: rows = {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};  // 4
         8'h35: rows = {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30}; // 5
         8'h36: rows = {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14}; // 6
         8'h37: rows = {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};  // 7
         8'h38: rows = {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14}; // 8
         8'h39: rows = {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}; // 9
         8'h28: rows = {5'd2,  5'd4,  5'd8,  5'd8,  5'd8,  5'd4,  5'd2};  // (
         8'h29: rows = {5'd8,  5'd4,  5'd2,  5'd2,  5'd2,  5'd4,  5'd8};  // )
         8'h5B: rows = {5'd14, 5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd14}; // [
         8'h5D: rows = {5'd14, 5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd14}; // ]
         8'h2D: rows = {5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0};  // -
         8'h2B: rows = {5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0};  // +
         8'h2E: rows = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12}; // .
         8'h3A: rows = {5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0};  // :
         8'h2F: rows = {5'd1,  5'd2,  5'd2,  5'd4,  5'd8,  5'd8,  5'd16}; // /
         8'h3E: rows = {5'd16, 5'd8,  5'd4,  5'd2,  5'd4,  5'd8,  5'd16}; // >
         8'h3C: rows = {5'd1,  5'd2,  5'd4,  5'd8,  5'd4,  5'd2,  5'd1};  // <
         8'h3D: rows = {5'd0,  5'd0,  5'd31, 5'd0,  5'd31, 5'd0,  5'd0};  // =
         8'h5F: rows = {5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31}; // _
         8'h3F: rows = {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd0,  5'd4};  // ?
         8'h21: rows = {5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd0,  5'd4};  // !
         8'h20: rows = '0;                                                // space
         // no glyph: fallback question-mark glyph
         default: rows = {5'd31, 5'd17, 5'd2, 5'd4, 5'd4, 5'd0, 5'd4};
      endcase
      return rows;
   endfunction

endpackage

`default_nettype wire

>>> rtl/tgr_req_if.sv
// Character request channel: valid/ready handshake and one character beat.
// Depends on tgr_pkg.
`default_nettype none

interface tgr_req_if;
   import tgr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CODE_W-1:0]          char_code;
   logic                       new_string;
   logic signed [START_W-1:0]  start_x;
   logic signed [START_W-1:0]  start_y;

   modport source (output valid, char_code, new_string, start_x, start_y, input ready);
   modport sink   (input valid, char_code, new_string, start_x, start_y, output ready);
endinterface

`default_nettype wire

>>> rtl/tgr_rsp_if.sv
// Square command channel: valid/ready handshake and one fill-square beat.
// Depends on tgr_pkg.
`default_nettype none

interface tgr_rsp_if #(
   parameter int COORD_WIDTH = tgr_pkg::COORD_WIDTH_DEF
);
   import tgr_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rect_x;
   logic signed [COORD_WIDTH-1:0] rect_y;
   logic [SCALE_W-1:0]            rect_size;
   logic [COLOUR_W-1:0]           draw_colour;
   logic                          last_of_char;

   modport source (output valid, rect_x, rect_y, rect_size, draw_colour, last_of_char,
                   input ready);
   modport sink   (input valid, rect_x, rect_y, rect_size, draw_colour, last_of_char,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/tgr_sat_add.sv
// Shared saturating adder: signed coordinate plus small unsigned offset,
// clamped to the top of the coordinate range. Depends on tgr_pkg.
`default_nettype none

module tgr_sat_add #(
   parameter int COORD_WIDTH = tgr_pkg::COORD_WIDTH_DEF
) (
   input  logic signed [COORD_WIDTH-1:0]   base,
   input  logic [tgr_pkg::OFFSET_W-1:0]    offset,
   output logic signed [COORD_WIDTH-1:0]   sum
);
   import tgr_pkg::*;

   // Two guard bits cover an offset larger than the narrowest range
   localparam int SUM_W = COORD_WIDTH + 2;
   localparam logic signed [SUM_W-1:0] MAX_V =
      SUM_W'((longint'(1) <<< (COORD_WIDTH - 1)) - 1);

   logic signed [SUM_W-1:0] wide;

   // Add, then clamp; the offset is never negative, so only the top can overflow
   always_comb begin
      wide = $signed(SUM_W'(base)) + $signed(SUM_W'(offset));
      if (wide > MAX_V) begin
         sum = MAX_V[COORD_WIDTH-1:0];
      end else begin
         sum = wide[COORD_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

>>> rtl/tgr_seq.sv
// Glyph sequencer: walks the 5x7 bitmap one bit a cycle, a lit bit only when the output
// slot is free, and steers the shared adder for rows, columns and cursor moves. Depends on tgr_pkg.
`default_nettype none

module tgr_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [tgr_pkg::CODE_W-1:0]    char_code,
   input  logic [tgr_pkg::SCALE_W-1:0]   scale,
   input  logic                          out_free,
   output logic                          idle,
   output tgr_pkg::tgr_ctrl_type         ctrl
);
   import tgr_pkg::*;

   tgr_state_type         state_ff, state_in;
   logic [GLYPH_BITS-1:0] glyph_ff, glyph_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [OFFSET_W-1:0]   col_off_ff, col_off_in;
   logic [OFFSET_W-1:0]   row_off_ff, row_off_in;

   logic [GLYPH_BITS-1:0] new_glyph;
   logic                  rest_empty;
   logic                  step;
   logic                  row_end;
   logic [OFFSET_W-1:0]   scale_ext;

   assign new_glyph  = glyph_bits(char_code);
   assign rest_empty = (glyph_ff[GLYPH_BITS-2:0] == '0);
   assign row_end    = (col_ff == COL_W'(GLYPH_COLS - 1));
   assign scale_ext  = OFFSET_W'(scale);
   // An unlit bit never waits for the output slot
   assign step       = (state_ff == ST_SCAN) && (!glyph_ff[GLYPH_BITS-1] || out_free);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (char_code == NUL_CODE || scale == '0) begin
                  state_in = ST_IDLE;
               end else if (char_code == NEWLINE_CODE) begin
                  state_in = ST_NEWLINE;
               end else if (new_glyph == '0) begin
                  state_in = ST_ADVANCE;
               end else begin
                  state_in = ST_ROW;
               end
            end
         end
         ST_ROW: state_in = ST_SCAN;
         ST_SCAN: begin
            if (step) begin
               if (rest_empty) begin
                  state_in = ST_ADVANCE;
               end else if (row_end) begin
                  state_in = ST_ROW;
               end
            end
         end
         ST_ADVANCE: state_in = ST_IDLE;
         ST_NEWLINE: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs to the datapath
   always_comb begin
      ctrl = '0;
      idle = 1'b0;
      case (state_ff)
         ST_IDLE: idle = 1'b1;
         ST_ROW: begin
            ctrl.row_wr = 1'b1;
            ctrl.base_y = 1'b1;
            ctrl.offset = row_off_ff;
         end
         ST_SCAN: begin
            ctrl.emit   = step && glyph_ff[GLYPH_BITS-1];
            ctrl.last   = rest_empty;
            ctrl.offset = col_off_ff;
         end
         ST_ADVANCE: begin
            ctrl.adv_wr = 1'b1;
            ctrl.offset = scale_ext * OFFSET_W'(CHAR_ADVANCE);
         end
         ST_NEWLINE: begin
            ctrl.line_wr = 1'b1;
            ctrl.base_y  = 1'b1;
            ctrl.offset  = scale_ext * OFFSET_W'(LINE_ADVANCE);
         end
         default: ctrl = '0;
      endcase
   end

   // Bitmap shift and offset counters
   always_comb begin
      glyph_in   = glyph_ff;
      col_in     = col_ff;
      col_off_in = col_off_ff;
      row_off_in = row_off_ff;
      if (accept) begin
         glyph_in   = new_glyph;
         col_in     = '0;
         col_off_in = '0;
         row_off_in = '0;
      end else if (step) begin
         glyph_in = {glyph_ff[GLYPH_BITS-2:0], 1'b0};
         if (row_end) begin
            col_in     = '0;
            col_off_in = '0;
            row_off_in = row_off_ff + scale_ext;
         end else begin
            col_in     = col_ff + 1'b1;
            col_off_in = col_off_ff + scale_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      glyph_ff   <= glyph_in;
      col_ff     <= col_in;
      col_off_ff <= col_off_in;
      row_off_ff <= row_off_in;
   end

endmodule

`default_nettype wire

>>> rtl/text_glyph_rectangle_generator.sv
// Text glyph rectangle generator: one square beat per lit pixel of a 5x7 glyph.
// The input is ready only while the sequencer is idle, so a character is taken
// only once the last is done. Per character it passes a row state per row and a
// scan state per bit up to the last lit pixel, stalling on output back-pressure,
// then a cursor state; newline and space take one cursor state, null or scale 0 none.
// Synchronous active-high reset clears cursor, line origin, scale to 1, colour to 0.
`default_nettype none

module text_glyph_rectangle_generator #(
   parameter int COORD_WIDTH = tgr_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   tgr_req_if.sink                           req,
   tgr_rsp_if.source                         rsp,
   input  logic                              csr_wr_en,
   input  logic [tgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tgr_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import tgr_pkg::*;

   localparam int EXT_W = (COORD_WIDTH > START_W) ? COORD_WIDTH : START_W;
   localparam logic signed [EXT_W-1:0] HI_EXT =
      EXT_W'((longint'(1) <<< (COORD_WIDTH - 1)) - 1);
   localparam logic signed [EXT_W-1:0] LO_EXT = -HI_EXT - EXT_W'(1);

   logic [SCALE_W-1:0]            scale_ff;
   logic [COLOUR_W-1:0]           colour_ff;
   logic signed [COORD_WIDTH-1:0] cursor_x_ff, cursor_x_in;
   logic signed [COORD_WIDTH-1:0] cursor_y_ff, cursor_y_in;
   logic signed [COORD_WIDTH-1:0] origin_x_ff, origin_x_in;
   logic signed [COORD_WIDTH-1:0] row_y_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_WIDTH-1:0] rsp_x_ff;
   logic signed [COORD_WIDTH-1:0] rsp_y_ff;
   logic                          rsp_last_ff;

   logic                          accept;
   logic                          idle;
   logic                          out_free;
   tgr_ctrl_type                  ctrl;
   logic signed [COORD_WIDTH-1:0] add_base;
   logic signed [COORD_WIDTH-1:0] add_sum;
   logic signed [EXT_W-1:0]       start_x_ext;
   logic signed [EXT_W-1:0]       start_y_ext;
   logic signed [COORD_WIDTH-1:0] start_x_sat;
   logic signed [COORD_WIDTH-1:0] start_y_sat;

   assign accept   = req.valid && req.ready;
   assign req.ready = idle;
   assign out_free = !rsp_valid_ff || rsp.ready;

   // Sequencer
   tgr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req.char_code),
      .scale     (scale_ff),
      .out_free  (out_free),
      .idle      (idle),
      .ctrl      (ctrl)
   );

   // Shared adder, fed from the cursor selected by the sequencer
   assign add_base = ctrl.base_y ? cursor_y_ff : cursor_x_ff;

   tgr_sat_add #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_add (
      .base   (add_base),
      .offset (ctrl.offset),
      .sum    (add_sum)
   );

   // Clamp string origin into the coordinate range
   always_comb begin
      start_x_ext = EXT_W'(req.start_x);
      start_y_ext = EXT_W'(req.start_y);
      if (start_x_ext > HI_EXT) begin
         start_x_sat = HI_EXT[COORD_WIDTH-1:0];
      end else if (start_x_ext < LO_EXT) begin
         start_x_sat = LO_EXT[COORD_WIDTH-1:0];
      end else begin
         start_x_sat = start_x_ext[COORD_WIDTH-1:0];
      end
      if (start_y_ext > HI_EXT) begin
         start_y_sat = HI_EXT[COORD_WIDTH-1:0];
      end else if (start_y_ext < LO_EXT) begin
         start_y_sat = LO_EXT[COORD_WIDTH-1:0];
      end else begin
         start_y_sat = start_y_ext[COORD_WIDTH-1:0];
      end
   end

   // Cursor and line origin
   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      origin_x_in = origin_x_ff;
      if (accept && req.new_string) begin
         cursor_x_in = start_x_sat;
         cursor_y_in = start_y_sat;
         origin_x_in = start_x_sat;
      end else if (ctrl.adv_wr) begin
         cursor_x_in = add_sum;
      end else if (ctrl.line_wr) begin
         cursor_x_in = origin_x_ff;
         cursor_y_in = add_sum;
      end
   end

   // Output slot: load on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= PIXEL_SCALE_RESET;
         colour_ff    <= FILL_COLOUR_RESET;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         origin_x_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_PIXEL_SCALE: scale_ff  <= csr_wr_data[SCALE_W-1:0];
               REG_FILL_COLOUR: colour_ff <= csr_wr_data[COLOUR_W-1:0];
               default: ;
            endcase
         end
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         origin_x_ff  <= origin_x_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Row y and square payload
   always_ff @(posedge clock) begin
      if (ctrl.row_wr) begin
         row_y_ff <= add_sum;
      end
      if (ctrl.emit) begin
         rsp_x_ff    <= add_sum;
         rsp_y_ff    <= row_y_ff;
         rsp_last_ff <= ctrl.last;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.rect_x       = rsp_x_ff;
   assign rsp.rect_y       = rsp_y_ff;
   assign rsp.rect_size    = scale_ff;
   assign rsp.draw_colour  = colour_ff;
   assign rsp.last_of_char = rsp_last_ff;

   // A square is only produced into a free output slot
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (!rsp_valid_ff || rsp.ready))
      else $error("square produced while output slot occupied");

   // No squares while the sequencer waits for a character
   a_idle_no_emit: assert property (@(posedge clock) disable iff (reset)
      idle |-> !ctrl.emit)
      else $error("square produced while idle");

   // Null code or zero scale completes in the accept cycle
   a_nothing_drawn: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.char_code == NUL_CODE || scale_ff == '0)) |=> idle)
      else $error("empty character left the sequencer busy");

endmodule

`default_nettype wire

>>> dv/text_glyph_rectangle_generator_tb.sv
// Self-checking testbench for text_glyph_rectangle_generator: drives character
// beats, predicts every square beat from its own font model and compares them.
// Depends on tgr_pkg, tgr_req_if, tgr_rsp_if and the block itself.
`default_nettype none

module text_glyph_rectangle_generator_tb;
   import tgr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W      = 16;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 12;
   // Margin for the longest character plus output stalls
   localparam int DRAIN_CYCLES = 64;
   localparam int STALL_LIMIT  = 4000;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef struct packed {
      logic [CODE_W-1:0]         char_code;
      logic                      new_string;
      logic signed [START_W-1:0] start_x;
      logic signed [START_W-1:0] start_y;
   } char_beat_t;

   typedef struct packed {
      logic signed [COORD_W-1:0] rect_x;
      logic signed [COORD_W-1:0] rect_y;
      logic [SCALE_W-1:0]        rect_size;
      logic [COLOUR_W-1:0]       draw_colour;
      logic                      last_of_char;
   } square_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   tgr_req_if                         req_if ();
   tgr_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_if ();

   text_glyph_rectangle_generator #(.COORD_WIDTH(COORD_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Model state of the text cursor and the registers
   logic signed [COORD_W-1:0] text_x;
   logic signed [COORD_W-1:0] text_y;
   logic signed [COORD_W-1:0] margin_x;
   logic [SCALE_W-1:0]        model_scale;
   logic [COLOUR_W-1:0]       model_colour;

   square_t     pending_squares[$];
   int          error_count;
   bit          idling_on;
   int          stall_left;
   int          quiet_cycles;
   string       glyph_chars;

   always #HALF_PERIOD clock = ~clock;

   function automatic logic signed [COORD_W-1:0] clamp_coord(input int v);
      if (v > int'(COORD_MAX)) return COORD_MAX;
      if (v < int'(COORD_MIN)) return COORD_MIN;
      return v[COORD_W-1:0];
   endfunction

   // Random start coordinate
   function automatic logic signed [START_W-1:0] rand_start();
      return START_W'($urandom());
   endfunction

   // 5x7 font, row 0 in the top five bits, leftmost column as the MSB of a row
   function automatic logic [GLYPH_BITS-1:0] glyph_pattern(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] key;
      key = code;
      if (key >= "a" && key <= "z") key = key - CASE_SHIFT;
      case (key)
         "A": return {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
         "B": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30};
         "C": return {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14};
         "D": return {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30};
         "E": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31};
         "F": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16};
         "G": return {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15};
         "H": return {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17};
         "I": return {5'd14, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
         "J": return {5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12};
         "K": return {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17};
         "L": return {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31};
         "M": return {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17};
         "N": return {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17};
         "O": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
         "P": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16};
         "Q": return {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13};
         "R": return {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17};
         "S": return {5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30};
         "T": return {5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4};
         "U": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14};
         "V": return {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4};
         "W": return {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10};
         "X": return {5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17};
         "Y": return {5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4};
         "Z": return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31};
         "0": return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
         "1": return {5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14};
         "2": return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31};
         "3": return {5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30};
         "4": return {5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2};
         "5": return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30};
         "6": return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
         "7": return {5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8};
         "8": return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
         "9": return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14};
         "(": return {5'd2, 5'd4, 5'd8, 5'd8, 5'd8, 5'd4, 5'd2};
         ")": return {5'd8, 5'd4, 5'd2, 5'd2, 5'd2, 5'd4, 5'd8};
         "[": return {5'd14, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd14};
         "]": return {5'd14, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd14};
         "-": return {5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0};
         "+": return {5'd0, 5'd4, 5'd4, 5'd31, 5'd4, 5'd4, 5'd0};
         ".": return {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd12, 5'd12};
         ":": return {5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0};
         "/": return {5'd1, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd16};
         ">": return {5'd16, 5'd8, 5'd4, 5'd2, 5'd4, 5'd8, 5'd16};
         "<": return {5'd1, 5'd2, 5'd4, 5'd8, 5'd4, 5'd2, 5'd1};
         "=": return {5'd0, 5'd0, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0};
         "_": return {5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd31};
         "?": return {5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4};
         "!": return {5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd0, 5'd4};
         " ": return '0;
         default: return {5'd31, 5'd17, 5'd2, 5'd4, 5'd4, 5'd0, 5'd4};
      endcase
   endfunction

   // Move the model cursor for one character and queue the squares it draws
   function automatic void predict_squares(input char_beat_t beat);
      logic [GLYPH_BITS-1:0] pattern;
      square_t               sq;
      int                    step;
      int                    lit_total;
      int                    lit_seen;
      step = int'(model_scale);
      if (beat.new_string) begin
         text_x   = clamp_coord(int'(beat.start_x));
         text_y   = clamp_coord(int'(beat.start_y));
         margin_x = text_x;
      end
      if (beat.char_code == NUL_CODE || step == 0) return;
      if (beat.char_code == NEWLINE_CODE) begin
         text_x = margin_x;
         text_y = clamp_coord(int'(text_y) + LINE_ADVANCE * step);
         return;
      end
      pattern   = glyph_pattern(beat.char_code);
      lit_total = $countones(pattern);
      lit_seen  = 0;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         for (int c = 0; c < GLYPH_COLS; c++) begin
            if (pattern[GLYPH_BITS - 1 - (r * GLYPH_COLS + c)]) begin
               sq.rect_x       = clamp_coord(int'(text_x) + c * step);
               sq.rect_y       = clamp_coord(int'(text_y) + r * step);
               sq.rect_size    = model_scale;
               sq.draw_colour  = model_colour;
               sq.last_of_char = (lit_seen == lit_total - 1);
               pending_squares.push_back(sq);
               lit_seen++;
            end
         end
      end
      text_x = clamp_coord(int'(text_x) + CHAR_ADVANCE * step);
   endfunction

   // Send one character beat, with an optional idle burst in front of it
   task automatic send_char(input logic [CODE_W-1:0] code, input logic fresh,
                            input logic signed [START_W-1:0] sx,
                            input logic signed [START_W-1:0] sy);
      char_beat_t beat;
      int         gap;
      beat = '{char_code: code, new_string: fresh, start_x: sx, start_y: sy};
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.char_code  <= beat.char_code;
      req_if.new_string <= beat.new_string;
      req_if.start_x    <= beat.start_x;
      req_if.start_y    <= beat.start_y;
      do @(posedge clock); while (!req_if.ready);
      predict_squares(beat);
   endtask

   // Drop valid and wait until the block has gone quiet
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (pending_squares.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      if (index == REG_PIXEL_SCALE) model_scale = data[SCALE_W-1:0];
      else if (index == REG_FILL_COLOUR) model_colour = data[COLOUR_W-1:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Scale register with random junk above the field
   task automatic set_scale(input logic [SCALE_W-1:0] s);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom();
      data[SCALE_W-1:0] = s;
      write_reg(REG_PIXEL_SCALE, data);
   endtask

   // Cursor starts at the origin with scale 1 and colour 0
   task automatic test_reset_defaults();
      send_char("H", 1'b0, rand_start(), rand_start());
      send_char("a", 1'b0, rand_start(), rand_start());
      send_char(NEWLINE_CODE, 1'b0, rand_start(), rand_start());
      send_char("I", 1'b0, rand_start(), rand_start());
   endtask

   // Largest scale, saturation, fallback glyphs, null, space and case folding
   task automatic test_glyph_extremes();
      wait_idle();
      set_scale(4'd15);
      write_reg(REG_FILL_COLOUR, 32'hFFFF_FFFF);
      send_char("W", 1'b1, COORD_MAX, COORD_MAX);
      send_char(NEWLINE_CODE, 1'b0, 16'sh0000, 16'sh0000);
      send_char("8", 1'b0, 16'sh0000, 16'sh0000);
      send_char(8'hFF, 1'b1, COORD_MIN, COORD_MIN);
      send_char(NUL_CODE, 1'b1, 16'sd100, -16'sd200);
      send_char(" ", 1'b0, rand_start(), rand_start());
      send_char("z", 1'b0, rand_start(), rand_start());
      send_char("!", 1'b0, rand_start(), rand_start());
      send_char(8'h80, 1'b0, rand_start(), rand_start());
      send_char(8'h7F, 1'b0, rand_start(), rand_start());
      send_char(NEWLINE_CODE, 1'b0, rand_start(), rand_start());
      send_char("M", 1'b0, rand_start(), rand_start());
   endtask

   // Scale zero draws nothing but a string load still lands
   task automatic test_scale_zero();
      wait_idle();
      set_scale(4'd0);
      write_reg(REG_FILL_COLOUR, 32'h0000_0000);
      send_char("M", 1'b1, 16'sd5, 16'sd7);
      send_char(NEWLINE_CODE, 1'b0, rand_start(), rand_start());
      send_char(8'hFF, 1'b0, rand_start(), rand_start());
      wait_idle();
      set_scale(4'd1);
      send_char("Q", 1'b0, rand_start(), rand_start());
   endtask

   // Random strings, mostly printable, with newlines, nulls and stray bytes
   task automatic test_random_text(input int n_items, input int scale_pick, input bit idle);
      int                        remaining;
      int                        len;
      int                        pick;
      logic [CODE_W-1:0]         code;
      logic                      fresh;
      logic signed [START_W-1:0] sx;
      logic signed [START_W-1:0] sy;
      wait_idle();
      idling_on = idle;
      if (scale_pick < 0) set_scale(SCALE_W'($urandom_range(0, 15)));
      else set_scale(scale_pick[SCALE_W-1:0]);
      write_reg(REG_FILL_COLOUR, $urandom());
      remaining = n_items;
      while (remaining > 0) begin
         len = $urandom_range(1, 12);
         for (int i = 0; i < len && remaining > 0; i++) begin
            fresh = (i == 0) ? 1'b1 : ($urandom_range(0, 19) == 0);
            pick  = $urandom_range(0, 99);
            if (pick < 70) code = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
            else if (pick < 80) code = NEWLINE_CODE;
            else if (pick < 85) code = NUL_CODE;
            else code = CODE_W'($urandom_range(0, 255));
            // Push a quarter of the strings against the top of the range
            if ($urandom_range(0, 3) == 0) begin
               sx = START_W'($urandom_range(32000, 32767));
               sy = START_W'($urandom_range(32000, 32767));
            end else begin
               sx = rand_start();
               sy = rand_start();
            end
            send_char(code, fresh, sx, sy);
            remaining--;
         end
      end
   endtask

   // Hold back the square channel in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 4);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Compare each square beat with the oldest prediction
   always @(posedge clock) begin
      square_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_squares.size() == 0) begin
            $display("%0t: square expected none actual x=%0d y=%0d", $time,
                     rsp_if.rect_x, rsp_if.rect_y);
            error_count++;
         end else begin
            want = pending_squares.pop_front();
            if (rsp_if.rect_x !== want.rect_x) begin
               $display("%0t: rect_x expected %0d actual %0d", $time,
                        want.rect_x, rsp_if.rect_x);
               error_count++;
            end
            if (rsp_if.rect_y !== want.rect_y) begin
               $display("%0t: rect_y expected %0d actual %0d", $time,
                        want.rect_y, rsp_if.rect_y);
               error_count++;
            end
            if (rsp_if.rect_size !== want.rect_size) begin
               $display("%0t: rect_size expected %0d actual %0d", $time,
                        want.rect_size, rsp_if.rect_size);
               error_count++;
            end
            if (rsp_if.draw_colour !== want.draw_colour) begin
               $display("%0t: draw_colour expected %h actual %h", $time,
                        want.draw_colour, rsp_if.draw_colour);
               error_count++;
            end
            if (rsp_if.last_of_char !== want.last_of_char) begin
               $display("%0t: last_of_char expected %b actual %b", $time,
                        want.last_of_char, rsp_if.last_of_char);
               error_count++;
            end
         end
      end
   end

   // Stop the run if neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.char_code  = '0;
      req_if.new_string = 1'b0;
      req_if.start_x    = '0;
      req_if.start_y    = '0;
      rsp_if.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wr_data       = '0;
      text_x            = '0;
      text_y            = '0;
      margin_x          = '0;
      model_scale       = PIXEL_SCALE_RESET;
      model_colour      = FILL_COLOUR_RESET;
      error_count       = 0;
      stall_left        = 0;
      quiet_cycles      = 0;
      idling_on         = 1'b1;
      glyph_chars = {"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz",
                     "0123456789()[]-+.:/><=_?! "};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_glyph_extremes();
      test_scale_zero();
      test_random_text(50, 1, 1'b1);
      test_random_text(40, 15, 1'b1);
      test_random_text(45, 2, 1'b1);
      test_random_text(15, 0, 1'b1);
      test_random_text(50, -1, 1'b1);
      test_random_text(45, 7, 1'b0);

      wait_idle();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> text_glyph_rectangle_generator.f
rtl/tgr_pkg.sv
rtl/tgr_req_if.sv
rtl/tgr_rsp_if.sv
rtl/tgr_sat_add.sv
rtl/tgr_seq.sv
rtl/text_glyph_rectangle_generator.sv
dv/text_glyph_rectangle_generator_tb.sv
